### rtl/led_pkg.sv
// ----------------------------------------------------------------------------
// led_pkg
// Shared types, sizes and helpers of the edit distance engine.
// ----------------------------------------------------------------------------
package led_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CHAR_W  = 16;
  localparam int CMD_W   = 2;
  localparam int DIST_W  = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef logic [LEN_W-1:0] cost_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST   = 2'd0,
    CMD_SECOND  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } state_t;

  function automatic logic [DIST_W-1:0] sat_dist(input cost_t v);
    if (32'(v) > 32'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return DIST_W'(v);
  endfunction

endpackage

### rtl/levenshtein_distance_engine.sv
// ----------------------------------------------------------------------------
// levenshtein_distance_engine
// Edit distance between two strings of 16-bit symbols, one cell per cycle within a row.
// ----------------------------------------------------------------------------
// Append words (command 0 or 1) add one symbol each; a symbol past 64 in a
// string is dropped and flags overflow on the next result. A compute word
// (command 2) walks the table row by row with one shared cell unit fed from
// a cost-row RAM. in_tready is low while a distance is being computed. One
// result word follows each compute word, and both strings and the overflow
// flag are cleared once it is accepted for work. Appends are taken while a
// finished result still waits on out_tready.
module levenshtein_distance_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] symbol
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [6:0] distance, [7] overflow
);
  import led_pkg::*;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [LEN_W-1:0]  second_len_r, second_len_nxt;
  logic              drop_r, drop_nxt;
  logic [LEN_W-1:0]  n1_r, n1_nxt;
  logic [LEN_W-1:0]  n2_r, n2_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LEN_W-1:0]  i_r, i_nxt;
  logic [LEN_W-1:0]  j_r, j_nxt;
  cost_t             left_r, left_nxt;
  cost_t             diag_r, diag_nxt;
  cost_t             res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              in_acc;
  cmd_t              cmd;
  logic              fc_we, sc_we, cr_we;
  logic [IDX_W-1:0]  fc_rd_addr, sc_rd_addr;
  char_t             fc_q, sc_q;
  cost_t             cr_q;
  cost_t             above;
  cost_t             best;
  logic              out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cmd        = cmd_t'(in_tuser);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign fc_we = in_acc && (cmd == CMD_FIRST) && (32'(first_len_r) < MAX_LEN);
  assign sc_we = in_acc && (cmd == CMD_SECOND) && (32'(second_len_r) < MAX_LEN);
  assign cr_we = (state_r == ST_CELL);

  // row symbol stays put for the whole row; column read runs one ahead
  assign fc_rd_addr = IDX_W'(i_r - 1'b1);
  assign sc_rd_addr = (state_r == ST_ROW) ? '0 : j_r[IDX_W-1:0];

  // first row reads the initial row j instead of the RAM
  assign above = (i_r == LEN_W'(1)) ? j_r : cr_q;

  led_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_first_ram (
    .clk     (clk),
    .wr_en   (fc_we),
    .wr_addr (first_len_r[IDX_W-1:0]),
    .wr_data (in_tdata),
    .rd_addr (fc_rd_addr),
    .rd_data (fc_q)
  );

  led_ram #(.DEPTH(MAX_LEN), .WIDTH(CHAR_W)) u_second_ram (
    .clk     (clk),
    .wr_en   (sc_we),
    .wr_addr (second_len_r[IDX_W-1:0]),
    .wr_data (in_tdata),
    .rd_addr (sc_rd_addr),
    .rd_data (sc_q)
  );

  led_ram #(.DEPTH(MAX_LEN), .WIDTH(LEN_W)) u_cost_ram (
    .clk     (clk),
    .wr_en   (cr_we),
    .wr_addr (IDX_W'(j_r - 1'b1)),
    .wr_data (best),
    .rd_addr (sc_rd_addr),
    .rd_data (cr_q)
  );

  led_cell u_cell (
    .above  (above),
    .left   (left_r),
    .diag   (diag_r),
    .char_a (fc_q),
    .char_b (sc_q),
    .best   (best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      first_len_r  <= '0;
      second_len_r <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      drop_r       <= drop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    ovf_r      <= ovf_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    left_r     <= left_nxt;
    diag_r     <= diag_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    first_len_nxt  = first_len_r;
    second_len_nxt = second_len_r;
    drop_nxt       = drop_r;
    n1_nxt         = n1_r;
    n2_nxt         = n2_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    left_nxt       = left_r;
    diag_nxt       = diag_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_FIRST: begin
              if (fc_we) begin
                first_len_nxt = first_len_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_SECOND: begin
              if (sc_we) begin
                second_len_nxt = second_len_r + 1'b1;
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              // latch lengths and flag, then empty both strings
              n1_nxt         = first_len_r;
              n2_nxt         = second_len_r;
              ovf_nxt        = drop_r;
              first_len_nxt  = '0;
              second_len_nxt = '0;
              drop_nxt       = 1'b0;
              i_nxt          = LEN_W'(1);
              left_nxt       = LEN_W'(1);
              diag_nxt       = '0;
              if (first_len_r == '0 || second_len_r == '0) begin
                res_nxt   = first_len_r | second_len_r;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_ROW;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ROW: begin
        j_nxt     = LEN_W'(1);
        state_nxt = ST_CELL;
      end
      ST_CELL: begin
        left_nxt = best;
        diag_nxt = above;
        j_nxt    = j_r + 1'b1;
        if (j_r == n2_r) begin
          if (i_r == n1_r) begin
            res_nxt   = best;
            state_nxt = ST_DONE;
          end else begin
            // next row: diag is old row index, left is new row index
            i_nxt     = i_r + 1'b1;
            diag_nxt  = i_r;
            left_nxt  = i_r + 1'b1;
            state_nxt = ST_ROW;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ovf_r, sat_dist(res_r)};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/led_ram.sv
// ----------------------------------------------------------------------------
// led_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module led_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/led_cell.sv
// ----------------------------------------------------------------------------
// led_cell
// One table cell: minimum of delete, insert and substitute cost.
// ----------------------------------------------------------------------------
module led_cell (
  input  led_pkg::cost_t above,
  input  led_pkg::cost_t left,
  input  led_pkg::cost_t diag,
  input  led_pkg::char_t char_a,
  input  led_pkg::char_t char_b,
  output led_pkg::cost_t best
);
  import led_pkg::*;

  logic [LEN_W:0] del_c;
  logic [LEN_W:0] ins_c;
  logic [LEN_W:0] sub_c;
  logic [LEN_W:0] min_c;

  always_comb begin
    del_c = {1'b0, above} + 1'b1;
    ins_c = {1'b0, left} + 1'b1;
    sub_c = {1'b0, diag} + {{LEN_W{1'b0}}, (char_a != char_b)};
    min_c = (del_c < ins_c) ? del_c : ins_c;
    if (sub_c < min_c) begin
      min_c = sub_c;
    end
    // a cell never exceeds MAX_LEN, so the top bit is always clear
    best = min_c[LEN_W-1:0];
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edit distance engine testbench
// Streams symbol appends and distance requests into the engine under several
// handshake idling patterns, predicts every result word with its own copy of
// both strings and a row-by-row cost table, and compares results in order.
// ----------------------------------------------------------------------------
module testbench;
  import led_pkg::*;

  typedef struct packed {
    logic              overflow;
    logic [DIST_W-1:0] distance;
  } dist_word_t;

  class edit_distance_board;
    char_t      first_str[MAX_LEN];
    char_t      second_str[MAX_LEN];
    int         first_len;
    int         second_len;
    bit         dropped;
    dist_word_t expected_words[$];
    int         errors;

    function int edit_distance();
      int row[MAX_LEN+1];
      int diag;
      int above;
      int best;
      for (int j = 0; j <= second_len; j++) begin
        row[j] = j;
      end
      for (int i = 1; i <= first_len; i++) begin
        diag = row[0];
        row[0] = i;
        for (int j = 1; j <= second_len; j++) begin
          above = row[j];
          best = diag + ((first_str[i-1] == second_str[j-1]) ? 0 : 1);
          if (above + 1 < best) begin
            best = above + 1;
          end
          if (row[j-1] + 1 < best) begin
            best = row[j-1] + 1;
          end
          row[j] = best;
          diag = above;
        end
      end
      return row[second_len];
    endfunction

    function void note_word(cmd_t c, char_t s);
      dist_word_t w;
      int d;
      case (c)
        CMD_FIRST: begin
          if (first_len < MAX_LEN) begin
            first_str[first_len] = s;
            first_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_SECOND: begin
          if (second_len < MAX_LEN) begin
            second_str[second_len] = s;
            second_len++;
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_COMPUTE: begin
          d = edit_distance();
          w.distance = (d > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(d);
          w.overflow = dropped;
          expected_words.push_back(w);
          first_len = 0;
          second_len = 0;
          dropped = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [7:0] data);
      dist_word_t got;
      dist_word_t want;
      got = data;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, data);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.distance !== want.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, want.distance,
                 got.distance);
        errors++;
      end
      if (got.overflow !== want.overflow) begin
        $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                 got.overflow);
        errors++;
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  edit_distance_board board = new();
  int idle_pct;
  int stall_pct;
  int words_sent;
  int quiet_cycles;
  bit hold_req;

  levenshtein_distance_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int held;
    held = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && held < 800) begin
        out_tready <= 1'b0;
        held++;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check results and watch for a hung handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        board.check_word(out_tdata);
      end
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(cmd_t c, char_t s);
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    board.note_word(c, s);
    if (c != CMD_NONE) begin
      words_sent++;
    end
  endtask

  function automatic char_t pick_symbol(char_t base, bit narrow);
    return narrow ? char_t'(base + $urandom_range(3)) : char_t'($urandom);
  endfunction

  // One pair of strings with interleaved appends, mostly closed by a request.
  task automatic send_string_pair(bit full);
    int    n1;
    int    n2;
    char_t base;
    bit    narrow;
    n1 = full ? $urandom_range(60, 68) : $urandom_range(0, 8);
    n2 = full ? $urandom_range(60, 68) : $urandom_range(0, 8);
    base = char_t'($urandom);
    narrow = ($urandom_range(3) != 0);
    while (n1 + n2 > 0) begin
      if ($urandom_range(24) == 0) begin
        send_word(CMD_NONE, char_t'($urandom));
      end
      if (n1 > 0 && (n2 == 0 || $urandom_range(1) == 1)) begin
        send_word(CMD_FIRST, pick_symbol(base, narrow));
        n1--;
      end else begin
        send_word(CMD_SECOND, pick_symbol(base, narrow));
        n2--;
      end
    end
    if ($urandom_range(19) != 0) begin
      send_word(CMD_COMPUTE, char_t'($urandom));
    end
  endtask

  task automatic run_phase(int in_pct, int out_pct, int quota);
    int start;
    idle_pct = in_pct;
    stall_pct = out_pct;
    start = words_sent;
    while (words_sent - start < quota) begin
      send_string_pair($urandom_range(39) == 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_FIRST;
    idle_pct = 0;
    stall_pct = 0;
    words_sent = 0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Both strings empty.
    send_word(CMD_COMPUTE, 16'hFFFF);
    // Second string empty; symbol extremes.
    send_word(CMD_FIRST, 16'h0000);
    send_word(CMD_FIRST, 16'hFFFF);
    send_word(CMD_COMPUTE, 16'h0000);
    // First string empty.
    send_word(CMD_SECOND, 16'hFFFF);
    send_word(CMD_COMPUTE, 16'h1234);
    // Substitution plus insertion.
    send_word(CMD_FIRST, 16'h0041);
    send_word(CMD_FIRST, 16'h0042);
    send_word(CMD_FIRST, 16'h0043);
    send_word(CMD_SECOND, 16'h0041);
    send_word(CMD_SECOND, 16'h0058);
    send_word(CMD_SECOND, 16'h0043);
    send_word(CMD_SECOND, 16'h0044);
    send_word(CMD_COMPUTE, 16'h0000);
    // Unused command must leave the strings alone.
    send_word(CMD_FIRST, 16'h8000);
    send_word(CMD_NONE, 16'hFFFF);
    send_word(CMD_SECOND, 16'h8000);
    send_word(CMD_COMPUTE, 16'h5555);

    hold_req = 1'b1;
    run_phase(0, 0, 100);
    // Overflow: first string overfilled, second one exactly full.
    for (int k = 0; k < 66; k++) begin
      send_word(CMD_FIRST, char_t'($urandom_range(1)));
    end
    for (int k = 0; k < MAX_LEN; k++) begin
      send_word(CMD_SECOND, char_t'($urandom_range(1)));
    end
    send_word(CMD_COMPUTE, char_t'($urandom));
    run_phase(75, 0, 130);
    run_phase(0, 75, 130);
    run_phase(25, 25, 130);
    in_tvalid <= 1'b0;

    while (board.expected_words.size() > 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);
    if (board.errors == 0 && board.expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### levenshtein_distance_engine.f
rtl/led_pkg.sv
rtl/led_ram.sv
rtl/led_cell.sv
rtl/levenshtein_distance_engine.sv
tb/sv/testbench.sv
